// File: rtl/core/nsl_pkg.sv
// Shared constants and types for the nearest site labeler.
// Used by the lane, tree, top level and checker files; depends on nothing.
package nsl_pkg;

	localparam int MAX_SITES  = 16;
	localparam int COORD_BITS = 16;

	// Fixed field widths of the ports.
	localparam int SLOT_BITS       = 4;
	localparam int COORD_IN_BITS   = 16;
	localparam int SITE_COUNT_BITS = 5;
	localparam int SITE_OUT_BITS   = 4;
	localparam int DIST_OUT_BITS   = 33;

	// The lane count is padded to a power of two so the minimum tree is full.
	localparam int SITE_IDX_BITS = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int LANES         = 1 << SITE_IDX_BITS;
	localparam int SQ_BITS       = 2 * COORD_BITS;
	localparam int DIST_BITS     = SQ_BITS + 1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic                     act;
		logic [SITE_IDX_BITS-1:0] idx;
		logic [DIST_BITS-1:0]     sq_dist;
	} node_t;

endpackage

// File: rtl/core/nearest_site_labeler_unit.sv
// Nearest site labeler: a site table with a pipelined squared-distance search.
// Depends on nsl_pkg, nsl_site_lanes and nsl_min_tree.
//
// Request channel (req_valid/req_stall): op, site_slot, coord_x, coord_y. A transfer
// with op load writes one site into the table and yields no response; a load to a
// slot at or above the table size is dropped. A transfer with op query yields one
// response (nearest_site, nearest_distance) on the rsp_valid/rsp_stall channel.
// Configuration channel (cfg_valid/cfg_ready): cfg_data sets site_count, the number
// of sites searched from entry 0; zero counts as one and large values as all sites.
// cfg_ready is always high; write only while no query is in flight.
// A query passes three lane stages (difference, square, sum) and one stage per level
// of the compare tree. One request per cycle is taken while req_stall is low.
// A load is visible to every query that transfers after it.
// Reset empties the pipeline and sets site_count to 1; the table is not cleared and
// a query must only touch sites that were loaded.
// While rsp_valid and rsp_stall are both high the whole pipeline holds and
// req_stall is raised; no request is taken until the response transfers.
module nearest_site_labeler_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                op,
	input  logic [nsl_pkg::SLOT_BITS-1:0]       site_slot,
	input  logic [nsl_pkg::COORD_IN_BITS-1:0]   coord_x,
	input  logic [nsl_pkg::COORD_IN_BITS-1:0]   coord_y,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [nsl_pkg::SITE_OUT_BITS-1:0]   nearest_site,
	output logic [nsl_pkg::DIST_OUT_BITS-1:0]   nearest_distance,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nsl_pkg::SITE_COUNT_BITS-1:0] cfg_data
);
	import nsl_pkg::*;

	logic                       adv;
	logic                       req_take;
	logic [SITE_COUNT_BITS-1:0] site_count_q;
	logic                       lane_vld;
	node_t [LANES-1:0]          lane_node;
	node_t                      best;

	assign cfg_ready = 1'b1;
	assign req_stall = rsp_valid && rsp_stall;
	assign adv       = !req_stall;
	assign req_take  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_count_q <= SITE_COUNT_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			site_count_q <= cfg_data;
		end
	end

	nsl_site_lanes u_lanes (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.load_we    (req_take && (op == OP_LOAD)),
		.query_we   (req_take && (op == OP_QUERY)),
		.slot       (site_slot),
		.qx         (coord_x[COORD_BITS-1:0]),
		.qy         (coord_y[COORD_BITS-1:0]),
		.site_count (site_count_q),
		.vld_s3     (lane_vld),
		.node_s3    (lane_node)
	);

	nsl_min_tree u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (lane_vld),
		.node_in (lane_node),
		.vld_out (rsp_valid),
		.best    (best)
	);

	assign nearest_site     = SITE_OUT_BITS'(best.idx);
	assign nearest_distance = DIST_OUT_BITS'(best.sq_dist);

endmodule

// File: rtl/core/nsl_site_lanes.sv
// Site table and per-site distance lanes: difference, square and sum stages.
// Depends on nsl_pkg.
module nsl_site_lanes (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 load_we,
	input  logic                                 query_we,
	input  logic [nsl_pkg::SLOT_BITS-1:0]        slot,
	input  nsl_pkg::coord_t                      qx,
	input  nsl_pkg::coord_t                      qy,
	input  logic [nsl_pkg::SITE_COUNT_BITS-1:0]  site_count,
	output logic                                 vld_s3,
	output nsl_pkg::node_t [nsl_pkg::LANES-1:0]  node_s3
);
	import nsl_pkg::*;

	logic vld_s1, vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= query_we;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		if (i < MAX_SITES) begin : g_site
			coord_t             site_x_q, site_y_q;
			coord_t             dx_s1, dy_s1;
			logic               act_s1, act_s2;
			logic [SQ_BITS-1:0] sqx_s2, sqy_s2;
			node_t              node_q;

			always_ff @(posedge clk) begin
				if (load_we && (int'(slot) == i)) begin
					site_x_q <= qx;
					site_y_q <= qy;
				end
			end

			// The table is read at acceptance, so a query sees every earlier load.
			always_ff @(posedge clk) begin
				if (adv) begin
					dx_s1          <= (qx >= site_x_q) ? (qx - site_x_q) : (site_x_q - qx);
					dy_s1          <= (qy >= site_y_q) ? (qy - site_y_q) : (site_y_q - qy);
					act_s1         <= (i == 0) || (int'(site_count) > i);
					sqx_s2         <= SQ_BITS'(dx_s1) * SQ_BITS'(dx_s1);
					sqy_s2         <= SQ_BITS'(dy_s1) * SQ_BITS'(dy_s1);
					act_s2         <= act_s1;
					node_q.act     <= act_s2;
					node_q.idx     <= SITE_IDX_BITS'(i);
					node_q.sq_dist <= DIST_BITS'(sqx_s2) + DIST_BITS'(sqy_s2);
				end
			end

			assign node_s3[i] = node_q;
		end else begin : g_pad
			assign node_s3[i] = '0;
		end
	end

endmodule

// File: rtl/core/nsl_min_tree.sv
// Registered minimum tree over the lane distances, one compare level per stage.
// Depends on nsl_pkg.
module nsl_min_tree (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                vld_in,
	input  nsl_pkg::node_t [nsl_pkg::LANES-1:0] node_in,
	output logic                                vld_out,
	output nsl_pkg::node_t                      best
);
	import nsl_pkg::*;

	localparam int L = SITE_IDX_BITS;

	node_t [LANES-1:0] cur   [0:L-1];
	node_t [LANES-1:0] nxt   [1:L];
	node_t [LANES-1:0] lvl_s [1:L];
	logic  [L:1]       vld_s;

	// Upper wins if active and closer or lower inactive; ties keep the lower index.
	function automatic node_t pick(node_t a, node_t b);
		if (b.act && (!a.act || (b.sq_dist < a.sq_dist))) begin
			return b;
		end
		return a;
	endfunction

	always_comb begin
		cur[0] = node_in;
		for (int k = 1; k < L; k++) begin
			cur[k] = lvl_s[k];
		end
		for (int k = 1; k <= L; k++) begin
			nxt[k] = '0;
			for (int j = 0; j < LANES / 2; j++) begin
				if (j < (LANES >> k)) begin
					nxt[k][j] = pick(cur[k-1][2*j], cur[k-1][2*j+1]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s[1] <= vld_in;
			for (int k = 2; k <= L; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= L; k++) begin
				lvl_s[k] <= nxt[k];
			end
		end
	end

	assign vld_out = vld_s[L];
	assign best    = lvl_s[L][0];

endmodule

// File: rtl/core/nsl_checker.sv
// Port-level checks for nearest_site_labeler_unit and the bind that attaches them.
// Depends on nsl_pkg.
module nsl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_stall,
	input logic                              rsp_valid,
	input logic                              rsp_stall,
	input logic [nsl_pkg::SITE_OUT_BITS-1:0] nearest_site,
	input logic [nsl_pkg::DIST_OUT_BITS-1:0] nearest_distance
);
	import nsl_pkg::*;

	localparam longint unsigned CMAX = (64'd1 << COORD_BITS) - 64'd1;
	localparam logic [DIST_OUT_BITS-1:0] DIST_MAX = DIST_OUT_BITS'(2 * CMAX * CMAX);

	// Requests are held back only by a response that cannot transfer.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled without a blocked response");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=>
			(rsp_valid && $stable(nearest_site) && $stable(nearest_distance)))
		else $error("stalled response changed");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (nearest_distance <= DIST_MAX))
		else $error("distance above the largest possible squared distance");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("response valid during reset");

endmodule

bind nearest_site_labeler_unit nsl_checker u_nsl_checker (.*);
